@@ src/twg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package twg_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int STEP_W      = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_TRIANGLE = 2'd1,
        SHAPE_SAWTOOTH = 2'd2,
        SHAPE_SQUARE   = 2'd3
    } t_shape;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SHAPE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_CODE  = 1'b1;

    typedef struct packed {
        t_shape              shape;
        logic [SAMPLE_W-1:0] peak;
    } t_cfg;

endpackage

`default_nettype wire

@@ src/twg_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module twg_datapath #(
    parameter int STEPS_PER_PERIOD = 50,
    parameter int SAMPLE_BITS      = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire logic [$clog2(STEPS_PER_PERIOD)-1:0] i_k,
    input  wire twg_pkg::t_cfg                    i_cfg,
    input  wire logic                             i_stall,
    output logic                                  o_adv,
    output logic                                  o_valid,
    output logic [twg_pkg::SAMPLE_W-1:0]          o_sample_code,
    output logic [twg_pkg::STEP_W-1:0]            o_step_index,
    output logic                                  o_period_end
);

    localparam int N  = STEPS_PER_PERIOD;
    localparam int KW = $clog2(N);
    localparam int H  = N / 2;
    localparam int SW = twg_pkg::SAMPLE_W;
    // dividend width for the triangle and sawtooth quotients: peak times at most N
    localparam int DW = SW + $clog2(N + 1);
    localparam int XW = 2 * SW;

    localparam logic [KW-1:0] HK   = KW'(H);
    localparam logic [KW-1:0] LAST = KW'(N - 1);
    localparam logic [KW:0]   NK   = (KW + 1)'(N);
    localparam logic [DW-1:0] DEN_TRI = DW'(H);
    localparam logic [DW-1:0] DEN_SAW = DW'(N);
    // floor(2^DW / D): the estimate (x * M) >> DW is the quotient or one below it
    localparam logic [DW-1:0] M_TRI = DW'((64'd1 << DW) / H);
    localparam logic [DW-1:0] M_SAW = DW'((64'd1 << DW) / N);
    localparam logic [SW-1:0] SAMPLE_MAX = SW'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // 32768 + sin(2*pi*k/N) in Q1.15, quadrant folded, Taylor series to x^13
    function automatic logic [15:0] sine_offset(input int k);
        longint unsigned m;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        m    = 64'(4 * k);
        quad = m / N;
        r    = m % N;
        if (quad[0]) begin
            r = longint'(N) - r;
        end
        x    = (HALF_PI_Q30 * r) / N;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 32767) begin
            q = 32767;
        end
        if (quad >= 2) begin
            q = -q;
        end
        return 16'(32768 + q);
    endfunction

    logic [SW-1:0] sine_rom [N];

    for (genvar g = 0; g < N; g++) begin : g_rom
        assign sine_rom[g] = sine_offset(g);
    end

    logic adv;
    logic is_div;
    logic is_tri;

    assign adv    = !o_valid || !i_stall;
    assign o_adv  = adv;
    assign is_tri = (i_cfg.shape == twg_pkg::SHAPE_TRIANGLE);
    assign is_div = is_tri || (i_cfg.shape == twg_pkg::SHAPE_SAWTOOTH);

    // stage 1: ROM read, triangle fold
    logic          r1_valid;
    logic [KW-1:0] r1_k;
    logic [SW-1:0] r1_rom;
    logic [KW-1:0] r1_tri;
    logic [KW-1:0] n1_tri;

    assign n1_tri = (i_k <= HK) ? i_k : KW'(NK - {1'b0, i_k});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_accept) begin
            r1_k   <= i_k;
            r1_rom <= sine_rom[i_k];
            r1_tri <= n1_tri;
        end
    end

    // stage 2: peak times shape operand
    logic          r2_valid;
    logic [KW-1:0] r2_k;
    logic [XW-1:0] r2_x;
    logic          r2_sq_hi;
    logic [SW-1:0] n2_a;

    always_comb begin
        case (i_cfg.shape)
            twg_pkg::SHAPE_SINE:     n2_a = r1_rom;
            twg_pkg::SHAPE_TRIANGLE: n2_a = SW'(r1_tri);
            twg_pkg::SHAPE_SAWTOOTH: n2_a = SW'(r1_k);
            default:                 n2_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_k     <= r1_k;
            r2_x     <= XW'(i_cfg.peak) * XW'(n2_a);
            r2_sq_hi <= (r1_k >= HK);
        end
    end

    // stage 3: reciprocal quotient estimate, or the final value for sine and square
    logic            r3_valid;
    logic [KW-1:0]   r3_k;
    logic [SW-1:0]   r3_q;
    logic [DW-1:0]   r3_x;
    logic [DW-1:0]   n3_m;
    logic [2*DW-1:0] n3_prod;
    logic [SW-1:0]   n3_q;

    assign n3_m    = is_tri ? M_TRI : M_SAW;
    assign n3_prod = (2 * DW)'(r2_x[DW-1:0]) * (2 * DW)'(n3_m);

    always_comb begin
        case (i_cfg.shape)
            twg_pkg::SHAPE_SINE:   n3_q = r2_x[XW-1:SW];
            twg_pkg::SHAPE_SQUARE: n3_q = r2_sq_hi ? i_cfg.peak : '0;
            default:               n3_q = n3_prod[DW +: SW];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_k <= r2_k;
            r3_q <= n3_q;
            r3_x <= r2_x[DW-1:0];
        end
    end

    // stage 4: remainder check fixes the estimate, then clamp
    logic [DW-1:0] n4_den;
    logic [DW-1:0] n4_rem;
    logic [SW-1:0] n4_q;
    logic [SW-1:0] n4_v;

    assign n4_den = is_tri ? DEN_TRI : DEN_SAW;
    assign n4_rem = r3_x - DW'(DW'(r3_q) * n4_den);
    assign n4_q   = (is_div && (n4_rem >= n4_den)) ? (r3_q + 1'b1) : r3_q;
    assign n4_v   = (n4_q > SAMPLE_MAX) ? SAMPLE_MAX : n4_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_sample_code <= n4_v;
            o_step_index  <= twg_pkg::STEP_W'(r3_k);
            o_period_end  <= (r3_k == LAST);
        end
    end

endmodule

`default_nettype wire

@@ src/table_waveform_generator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Periodic DAC waveform source. Every accepted input beat is one tick and yields one
// result beat: the sample code for the current phase step, the step index and a flag on
// the last step of the period. The phase advances one step per tick and wraps after
// STEPS_PER_PERIOD steps; restart puts it back to step zero before that tick's sample.
// Sine comes from a constant full-period table, triangle and sawtooth from a multiply
// and an exact reciprocal division, square from a compare. One beat is taken every clock
// unless a held result stalls, which freezes the whole four-stage datapath (ROM read,
// peak multiply, reciprocal multiply, remainder fix and clamp). Shape and peak must be
// written only while the block is idle; the block does not enforce this. Index 0 shape
// (0 sine, 1 triangle, 2 sawtooth, 3 square), index 1 peak code.

module table_waveform_generator_core #(
    parameter int STEPS_PER_PERIOD = 50,
    parameter int SAMPLE_BITS      = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [twg_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [twg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_valid,
    input  wire logic                               i_restart,
    output logic                                    o_stall,
    output logic                                    o_valid,
    output logic [twg_pkg::SAMPLE_W-1:0]            o_sample_code,
    output logic [twg_pkg::STEP_W-1:0]              o_step_index,
    output logic                                    o_period_end,
    input  wire logic                               i_stall
);

    localparam int KW = $clog2(STEPS_PER_PERIOD);
    localparam logic [KW-1:0] LAST = KW'(STEPS_PER_PERIOD - 1);

    twg_pkg::t_cfg r_cfg;
    logic [KW-1:0] r_phase;
    logic [KW-1:0] n_phase;
    logic [KW-1:0] k;
    logic          adv;
    logic          accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shape <= twg_pkg::SHAPE_SINE;
            r_cfg.peak  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                twg_pkg::CFG_WAVE_SHAPE: r_cfg.shape <= twg_pkg::t_shape'(i_cfg_data[1:0]);
                twg_pkg::CFG_PEAK_CODE:  r_cfg.peak  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept  = i_valid && adv;
    assign o_stall = !adv;
    assign k       = i_restart ? '0 : r_phase;
    assign n_phase = (k == LAST) ? '0 : (k + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    twg_datapath #(
        .STEPS_PER_PERIOD (STEPS_PER_PERIOD),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_k           (k),
        .i_cfg         (r_cfg),
        .i_stall       (i_stall),
        .o_adv         (adv),
        .o_valid       (o_valid),
        .o_sample_code (o_sample_code),
        .o_step_index  (o_step_index),
        .o_period_end  (o_period_end)
    );

endmodule

`default_nettype wire
